>>> hdl/dsf_pkg.sv
// Shared types and constants for the deep sample flattener.
// Item structs for both channels, accumulator state and fixed-point limits.
// No dependencies.
package dsf_pkg;

	localparam logic [16:0] ONE_Q16      = 17'd65536;
	localparam logic [15:0] HALF_Q16     = 16'd32768;
	localparam logic [23:0] COLOR_MAX    = 24'h7FFFFF;
	localparam logic [23:0] COLOR_MIN    = 24'h800000;
	localparam logic [23:0] DEPTH_FAR    = 24'hFFFFFF;
	// three alphas all at one: mean has reached one
	localparam logic [18:0] OPAQUE_SUM   = 19'd196608;
	// floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for x < 2**19
	localparam logic [17:0] RECIP3       = 18'd174763;
	localparam int          RECIP3_SHIFT = 19;

	localparam logic REG_HAS_DEPTH      = 1'b0;
	localparam logic REG_HAS_DEPTH_BACK = 1'b1;

	typedef struct packed {
		logic signed [23:0] red;
		logic signed [23:0] green;
		logic signed [23:0] blue;
		logic [16:0]        alpha_red;
		logic [16:0]        alpha_green;
		logic [16:0]        alpha_blue;
		logic [23:0]        depth_front;
		logic [23:0]        depth_rear;
		logic               first_sample;
		logic               last_sample;
		logic               empty_pixel;
	} sample_t;

	typedef struct packed {
		logic signed [23:0] out_red;
		logic signed [23:0] out_green;
		logic signed [23:0] out_blue;
		logic [16:0]        out_alpha_red;
		logic [16:0]        out_alpha_green;
		logic [16:0]        out_alpha_blue;
		logic [23:0]        out_depth_front;
		logic [23:0]        out_depth_rear;
	} pixel_t;

	typedef struct packed {
		logic [2:0][23:0] color;
		logic [2:0][16:0] alpha;
		logic [1:0][23:0] depth;
	} acc_t;

	typedef struct packed {
		logic has_depth;
		logic has_depth_back;
	} cfg_t;

endpackage

>>> hdl/dsf_update.sv
// One compositing step: next accumulator state and the flat pixel it gives.
// Purely combinational; sits between the sample register and the accumulators.
// Depends on dsf_pkg.
module dsf_update import dsf_pkg::*; (
	input  sample_t item,
	input  acc_t    acc,
	input  cfg_t    cfg,
	output acc_t    nxt,
	output pixel_t  result
);

	acc_t             base;
	acc_t             upd;
	logic [18:0]      asum;
	logic [36:0]      mean_prod;
	logic [16:0]      mean;
	logic [16:0]      wmean;
	logic             opaque;
	logic [2:0][23:0] vcol;
	logic [2:0][16:0] valpha;
	logic [1:0][23:0] vdepth;

	// first sample of a pixel starts from clear sums
	assign base = item.first_sample ? '0 : acc;

	assign asum      = {2'b00, base.alpha[0]} + {2'b00, base.alpha[1]} + {2'b00, base.alpha[2]};
	assign mean_prod = {18'd0, asum} * {19'd0, RECIP3};
	assign mean      = mean_prod[RECIP3_SHIFT +: 17];
	assign wmean     = ONE_Q16 - mean;
	assign opaque    = asum >= OPAQUE_SUM;

	assign vcol   = {item.blue, item.green, item.red};
	assign valpha = {item.alpha_blue, item.alpha_green, item.alpha_red};
	assign vdepth = {item.depth_rear, item.depth_front};

	for (genvar i = 0; i < 3; i++) begin : g_chan
		logic [16:0]        wc;
		logic signed [41:0] cprod;
		logic signed [41:0] crnd;
		logic signed [26:0] csum;
		logic [23:0]        csat;
		logic [16:0]        ain;
		logic [33:0]        aprod;
		logic [34:0]        arnd;
		logic [19:0]        anew;
		logic [16:0]        asat;

		assign wc    = ONE_Q16 - base.alpha[i];
		assign cprod = $signed({1'b0, wc}) * $signed(vcol[i]);
		assign crnd  = cprod + $signed({26'd0, HALF_Q16});
		// arithmetic floor after the half bias: round half up
		assign csum  = $signed({{3{base.color[i][23]}}, base.color[i]})
			+ $signed({crnd[41], crnd[41:16]});

		assign csat = (csum > $signed({{3{1'b0}}, COLOR_MAX})) ? COLOR_MAX
			: (csum < $signed({{3{1'b1}}, COLOR_MIN})) ? COLOR_MIN
			: csum[23:0];

		assign ain   = (valpha[i] > ONE_Q16) ? ONE_Q16 : valpha[i];
		assign aprod = {17'd0, wmean} * {17'd0, ain};
		assign arnd  = {1'b0, aprod} + {19'd0, HALF_Q16};
		assign anew  = {3'd0, base.alpha[i]} + {1'b0, arnd[34:16]};

		assign asat = (anew > {3'd0, ONE_Q16}) ? ONE_Q16 : anew[16:0];
	end

	for (genvar j = 0; j < 2; j++) begin : g_depth
		logic        en;
		logic [40:0] dkeep;
		logic [40:0] dadd;
		logic [41:0] dsum;
		logic [25:0] dnew;
		logic [23:0] dsat;

		assign en    = (j == 0) ? cfg.has_depth : cfg.has_depth_back;
		assign dkeep = {17'd0, base.depth[j]} * {24'd0, mean};
		assign dadd  = {17'd0, vdepth[j]} * {24'd0, wmean};
		assign dsum  = {1'b0, dkeep} + {1'b0, dadd} + {26'd0, HALF_Q16};
		assign dnew  = dsum[41:16];

		assign dsat = !en ? base.depth[j]
			: (dnew > {2'b00, DEPTH_FAR}) ? DEPTH_FAR
			: dnew[23:0];
	end

	assign upd = {g_chan[2].csat, g_chan[1].csat, g_chan[0].csat,
		g_chan[2].asat, g_chan[1].asat, g_chan[0].asat,
		g_depth[1].dsat, g_depth[0].dsat};

	always_comb begin
		if (item.empty_pixel) begin
			nxt                    = '0;
			result                 = '0;
			result.out_depth_front = cfg.has_depth ? DEPTH_FAR : '0;
			result.out_depth_rear  = cfg.has_depth_back ? DEPTH_FAR : '0;
		end else begin
			nxt                    = opaque ? base : upd;
			result.out_red         = nxt.color[0];
			result.out_green       = nxt.color[1];
			result.out_blue        = nxt.color[2];
			result.out_alpha_red   = nxt.alpha[0];
			result.out_alpha_green = nxt.alpha[1];
			result.out_alpha_blue  = nxt.alpha[2];
			result.out_depth_front = cfg.has_depth ? nxt.depth[0] : '0;
			result.out_depth_rear  = cfg.has_depth_back ? nxt.depth[1] : '0;
		end
	end

endmodule

>>> hdl/deep_sample_flatten_top.sv
// Deep sample flattener: front-to-back over compositing of one deep pixel.
// A last or empty sample is held in item_s1, then its pixel is registered in pixel_q.
// Throughput: one sample per cycle; the accumulator loop (alpha mean, weight
// multiply, saturate) is one combinational path back to acc_q. Input stalls only behind a stalled pixel.
// Reset: accumulators cleared, both depth channels enabled, pipeline empty.
// Depends on dsf_pkg and dsf_update.
module deep_sample_flatten_top import dsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  sample_t     sample,
	output logic        pixel_valid,
	input  logic        pixel_stall,
	output pixel_t      pixel,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	sample_t item_s1;
	logic    valid_s1;
	acc_t    acc_q;
	acc_t    acc_nxt;
	pixel_t  result;
	pixel_t  pixel_q;
	logic    pixel_valid_q;
	cfg_t    cfg_q;
	logic    emits;
	logic    out_free;
	logic    commit;
	logic    accept;
	logic    cfg_wr;

	// config registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{has_depth: 1'b1, has_depth_back: 1'b1};
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_HAS_DEPTH:      cfg_q.has_depth      <= pwdata[0];
				REG_HAS_DEPTH_BACK: cfg_q.has_depth_back <= pwdata[0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_HAS_DEPTH:      prdata = {31'd0, cfg_q.has_depth};
			REG_HAS_DEPTH_BACK: prdata = {31'd0, cfg_q.has_depth_back};
			default:            prdata = '0;
		endcase
	end

	// handshake: the held item commits unless its pixel has nowhere to go
	assign emits        = item_s1.last_sample || item_s1.empty_pixel;
	assign out_free     = !pixel_valid_q || !pixel_stall;
	assign commit       = valid_s1 && (!emits || out_free);
	assign sample_stall = valid_s1 && !commit;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= sample;
		end
	end

	dsf_update u_update (
		.item   (item_s1),
		.acc    (acc_q),
		.cfg    (cfg_q),
		.nxt    (acc_nxt),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (commit) begin
			acc_q <= acc_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid_q <= 1'b0;
		end else if (out_free) begin
			pixel_valid_q <= commit && emits;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && emits) begin
			pixel_q <= result;
		end
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel       = pixel_q;

	// alpha sums stay within one
	a_alpha_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q.alpha[0] <= ONE_Q16 && acc_q.alpha[1] <= ONE_Q16 && acc_q.alpha[2] <= ONE_Q16)
		else $error("alpha accumulator above one");

	// a sample that makes no pixel never waits
	a_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !item_s1.last_sample && !item_s1.empty_pixel) |-> commit)
		else $error("non-emitting item held back");

	// the input stalls only behind a stalled pixel
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && pixel_valid_q && pixel_stall))
		else $error("input stalled without output backpressure");

	// an empty pixel clears the sums and shows a result
	a_empty_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && item_s1.empty_pixel) |=> (acc_q == '0 && pixel_valid_q))
		else $error("empty pixel did not clear state");

endmodule

>>> tb/deep_sample_flatten_checker.sv
`timescale 1ns / 1ps
// Checker for the deep sample flattener: watches the sample, pixel and register
// channels, predicts each flat pixel and compares it field by field.
// Depends on dsf_pkg.
module deep_sample_flatten_checker import dsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	input  logic        sample_stall,
	input  sample_t     sample,
	input  logic        pixel_valid,
	input  logic        pixel_stall,
	input  pixel_t      pixel,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	localparam longint Q16_ONE  = 65536;
	localparam longint Q16_HALF = 32768;
	localparam longint SUM_CMAX = 8388607;
	localparam longint SUM_CMIN = -8388608;
	localparam longint SUM_DMAX = 16777215;

	cfg_t   cfg;
	longint color_sum[3];
	longint alpha_sum[3];
	longint depth_sum[2];
	bit     opaque;
	pixel_t flat_pixels[$];
	int     errors_seen = 0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		if (errors_seen < 40)
			$display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
		errors_seen++;
	endtask

	task automatic clear_sums();
		for (int i = 0; i < 3; i++) begin
			color_sum[i] = 0;
			alpha_sum[i] = 0;
		end
		depth_sum[0] = 0;
		depth_sum[1] = 0;
		opaque = 1'b0;
	endtask

	// depth is scaled by the old mean, then the new depth weighted by 1 - mean
	function automatic longint next_depth(input longint acc, input longint v, input longint mean);
		longint r;
		r = (acc * mean + (Q16_ONE - mean) * v + Q16_HALF) >>> 16;
		return (r > SUM_DMAX) ? SUM_DMAX : r;
	endfunction

	task automatic composite_sample(input sample_t s);
		longint col_in[3];
		longint alp_in[3];
		longint prev_alpha[3];
		longint mean;
		longint acc;
		longint w;
		pixel_t px;
		px = '0;
		if (s.empty_pixel) begin
			clear_sums();
			px.out_depth_front = cfg.has_depth ? DEPTH_FAR : '0;
			px.out_depth_rear  = cfg.has_depth_back ? DEPTH_FAR : '0;
			flat_pixels.push_back(px);
			return;
		end
		if (s.first_sample)
			clear_sums();
		if (!opaque) begin
			col_in[0] = $signed(s.red);
			col_in[1] = $signed(s.green);
			col_in[2] = $signed(s.blue);
			alp_in[0] = s.alpha_red;
			alp_in[1] = s.alpha_green;
			alp_in[2] = s.alpha_blue;
			for (int i = 0; i < 3; i++)
				prev_alpha[i] = alpha_sum[i];
			mean = (prev_alpha[0] + prev_alpha[1] + prev_alpha[2]) / 3;
			for (int i = 0; i < 3; i++) begin
				acc = color_sum[i] + (((Q16_ONE - prev_alpha[i]) * col_in[i] + Q16_HALF) >>> 16);
				color_sum[i] = (acc > SUM_CMAX) ? SUM_CMAX : ((acc < SUM_CMIN) ? SUM_CMIN : acc);
			end
			for (int i = 0; i < 3; i++) begin
				w = (alp_in[i] > Q16_ONE) ? Q16_ONE : alp_in[i];
				acc = prev_alpha[i] + (((Q16_ONE - mean) * w + Q16_HALF) >>> 16);
				alpha_sum[i] = (acc > Q16_ONE) ? Q16_ONE : acc;
			end
			if (cfg.has_depth)
				depth_sum[0] = next_depth(depth_sum[0], longint'(s.depth_front), mean);
			if (cfg.has_depth_back)
				depth_sum[1] = next_depth(depth_sum[1], longint'(s.depth_rear), mean);
			opaque = ((alpha_sum[0] + alpha_sum[1] + alpha_sum[2]) / 3) >= Q16_ONE;
		end
		if (s.last_sample) begin
			px.out_red         = 24'(color_sum[0]);
			px.out_green       = 24'(color_sum[1]);
			px.out_blue        = 24'(color_sum[2]);
			px.out_alpha_red   = 17'(alpha_sum[0]);
			px.out_alpha_green = 17'(alpha_sum[1]);
			px.out_alpha_blue  = 17'(alpha_sum[2]);
			px.out_depth_front = cfg.has_depth ? 24'(depth_sum[0]) : '0;
			px.out_depth_rear  = cfg.has_depth_back ? 24'(depth_sum[1]) : '0;
			flat_pixels.push_back(px);
		end
	endtask

	task automatic compare_pixel(input pixel_t got, input pixel_t want);
		if (got.out_red !== want.out_red)
			report("out_red", got.out_red, want.out_red);
		if (got.out_green !== want.out_green)
			report("out_green", got.out_green, want.out_green);
		if (got.out_blue !== want.out_blue)
			report("out_blue", got.out_blue, want.out_blue);
		if (got.out_alpha_red !== want.out_alpha_red)
			report("out_alpha_red", got.out_alpha_red, want.out_alpha_red);
		if (got.out_alpha_green !== want.out_alpha_green)
			report("out_alpha_green", got.out_alpha_green, want.out_alpha_green);
		if (got.out_alpha_blue !== want.out_alpha_blue)
			report("out_alpha_blue", got.out_alpha_blue, want.out_alpha_blue);
		if (got.out_depth_front !== want.out_depth_front)
			report("out_depth_front", got.out_depth_front, want.out_depth_front);
		if (got.out_depth_rear !== want.out_depth_rear)
			report("out_depth_rear", got.out_depth_rear, want.out_depth_rear);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t      want;
		logic [31:0] rd_want;
		if (!arst_n) begin
			cfg.has_depth      = 1'b1;
			cfg.has_depth_back = 1'b1;
			clear_sums();
			flat_pixels.delete();
			pending <= 0;
		end else begin
			// a pixel leaving now was caused by an earlier item, so check it first
			if (pixel_valid && !pixel_stall) begin
				if (flat_pixels.size() == 0) begin
					report("flat pixel with none expected", '0, '0);
				end else begin
					want = flat_pixels.pop_front();
					compare_pixel(pixel, want);
				end
			end
			if (sample_valid && !sample_stall)
				composite_sample(sample);
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_HAS_DEPTH)
						cfg.has_depth = pwdata[0];
					else
						cfg.has_depth_back = pwdata[0];
				end else begin
					rd_want = {31'b0, (paddr[2] == REG_HAS_DEPTH) ? cfg.has_depth
						: cfg.has_depth_back};
					if (prdata !== rd_want)
						report("register read", prdata, rd_want);
				end
			end
			pending    <= flat_pixels.size();
			fail_count <= errors_seen;
		end
	end

endmodule

>>> tb/tb_deep_sample_flatten_top.sv
`timescale 1ns / 1ps
// Testbench top for the deep sample flattener: clock, reset, sample and register
// stimulus, random pixel backpressure and the verdict. Depends on dsf_pkg,
// deep_sample_flatten_top and deep_sample_flatten_checker.
module tb_deep_sample_flatten_top;
	import dsf_pkg::*;

	localparam int PHASE_ITEMS = 160;
	localparam int CYCLE_LIMIT = 300000;
	localparam logic [2:0] ADDR_HAS_DEPTH      = {REG_HAS_DEPTH, 2'b00};
	localparam logic [2:0] ADDR_HAS_DEPTH_BACK = {REG_HAS_DEPTH_BACK, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_stall;
	sample_t     sample;
	logic        pixel_valid;
	logic        pixel_stall;
	pixel_t      pixel;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	int          sent = 0;
	int          send_calm = 0;
	int          cycles = 0;

	always #6 clk = ~clk;

	deep_sample_flatten_top dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	deep_sample_flatten_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [23:0] rand_color();
		case ($urandom_range(0, 7))
			0: return COLOR_MAX;
			1: return COLOR_MIN;
			2: return '0;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [16:0] rand_alpha();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ONE_Q16;
			2: return 17'($urandom_range(65537, 131071));
			3: return 17'($urandom_range(0, 255));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [23:0] rand_depth();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DEPTH_FAR;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic sample_t mk(input logic [23:0] r, input logic [23:0] g,
			input logic [23:0] b, input logic [16:0] ar, input logic [16:0] ag,
			input logic [16:0] ab, input logic [23:0] df, input logic [23:0] dr,
			input logic f, input logic l, input logic e);
		sample_t s;
		s.red = r;
		s.green = g;
		s.blue = b;
		s.alpha_red = ar;
		s.alpha_green = ag;
		s.alpha_blue = ab;
		s.depth_front = df;
		s.depth_rear = dr;
		s.first_sample = f;
		s.last_sample = l;
		s.empty_pixel = e;
		return s;
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		s = mk(rand_color(), rand_color(), rand_color(), rand_alpha(), rand_alpha(),
			rand_alpha(), rand_depth(), rand_depth(), 1'b0, 1'b0, 1'b0);
		// solid sample: drives the pixel opaque quickly
		if ($urandom_range(0, 7) == 0) begin
			s.alpha_red = ONE_Q16;
			s.alpha_green = ONE_Q16;
			s.alpha_blue = 17'($urandom_range(65536, 131071));
		end
		return s;
	endfunction

	task automatic send(input sample_t s);
		int gap;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else begin
			if ($urandom_range(0, 19) == 0)
				send_calm = 30;
			gap = $urandom_range(0, 12);
		end
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		sent++;
	endtask

	// stop sending and let every expected pixel come out
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel();
		int kind;
		int len;
		sample_t s;
		kind = $urandom_range(0, 99);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
		if (kind < 8) begin
			s = rand_sample();
			s.first_sample = 1'($urandom);
			s.last_sample = 1'($urandom);
			s.empty_pixel = 1'b1;
			send(s);
			return;
		end
		// 8..13: no first sample, 14..19: no last sample, rest well formed
		for (int i = 0; i < len; i++) begin
			s = rand_sample();
			s.first_sample = (i == 0) && (kind >= 14);
			s.last_sample = (i == len - 1) && !(kind >= 14 && kind < 20);
			s.empty_pixel = ($urandom_range(0, 39) == 0);
			send(s);
		end
	endtask

	initial begin : pixel_sink
		int hold;
		int calm;
		calm = 0;
		forever begin
			if (calm > 0) begin
				hold = 0;
				calm--;
			end else begin
				if ($urandom_range(0, 19) == 0)
					calm = 30;
				hold = $urandom_range(0, 12);
			end
			if (hold > 0) begin
				pixel_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			pixel_stall <= 1'b0;
			@(posedge clk);
			while (!pixel_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int target;
		bit paused;
		paused = 1'b0;
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, ADDR_HAS_DEPTH, '0);
		apb_access(1'b0, ADDR_HAS_DEPTH_BACK, '0);

		// empty pixel, other fields ignored
		send(mk(24'h123456, 24'h654321, 24'h0F0F0F, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
			24'hABCDEF, 24'h000001, 1'b0, 1'b0, 1'b1));
		// one-sample pixel with extremes and an alpha above one
		send(mk(COLOR_MAX, COLOR_MIN, '0, ONE_Q16, '0, 17'h1FFFF, '0, DEPTH_FAR,
			1'b1, 1'b1, 1'b0));
		// color sums saturate both ways
		send(mk(COLOR_MAX, COLOR_MIN, COLOR_MAX, '0, '0, '0, DEPTH_FAR, DEPTH_FAR,
			1'b1, 1'b0, 1'b0));
		send(mk(COLOR_MAX, COLOR_MIN, 24'h400000, 17'd1, 17'd2, 17'd3, DEPTH_FAR, '0,
			1'b0, 1'b0, 1'b0));
		send(mk(24'h000001, 24'hFFFFFF, COLOR_MAX, 17'd65535, '0, 17'd32768, 24'h800000,
			DEPTH_FAR, 1'b0, 1'b1, 1'b0));
		// opaque first sample, later samples ignored
		send(mk(24'h010000, 24'h020000, 24'hFF0000, ONE_Q16, ONE_Q16, ONE_Q16, 24'h100000,
			24'h200000, 1'b1, 1'b0, 1'b0));
		send(mk(COLOR_MAX, COLOR_MAX, COLOR_MAX, '0, '0, '0, DEPTH_FAR, DEPTH_FAR,
			1'b0, 1'b0, 1'b0));
		send(mk(COLOR_MIN, COLOR_MIN, COLOR_MIN, 17'd100, 17'd100, 17'd100, '0, '0,
			1'b0, 1'b1, 1'b0));
		// no first sample while still opaque
		send(mk(24'h7F0000, 24'h000100, 24'h800001, 17'd500, 17'd600, 17'd700, 24'h00FF00,
			24'h0000FF, 1'b0, 1'b1, 1'b0));
		send(mk('0, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1));
		// no first sample after a clear
		send(mk(24'h7F0000, 24'h812345, 24'h00ABCD, 17'd40000, 17'd50000, 17'd60000,
			24'h00FFFF, 24'hFFFF00, 1'b0, 1'b0, 1'b0));
		send(mk(24'h100000, 24'hF00000, 24'h000001, 17'd65535, 17'd65535, 17'd65535,
			DEPTH_FAR, 24'h000010, 1'b0, 1'b1, 1'b0));
		// partial alphas accumulate toward one
		send(mk(COLOR_MIN, 24'hFFFFFF, 24'h0000FF, 17'd1, 17'd32768, 17'd65535,
			24'h555555, 24'hAAAAAA, 1'b1, 1'b0, 1'b0));
		send(mk(24'hFF8000, 24'h008000, COLOR_MAX, 17'd65535, 17'd65536, 17'd98304,
			24'h123456, 24'h654321, 1'b0, 1'b0, 1'b0));
		send(mk(24'h000010, 24'hFFFFF0, 24'h7FFF00, 17'h1FFFF, 17'd1, 17'd0, DEPTH_FAR,
			DEPTH_FAR, 1'b0, 1'b1, 1'b0));
		// empty pixel with the other flags set too
		send(mk(COLOR_MAX, COLOR_MAX, COLOR_MAX, ONE_Q16, ONE_Q16, ONE_Q16, '0, '0,
			1'b1, 1'b1, 1'b1));
		// restart in the middle of a pixel
		send(mk(24'h200000, 24'h300000, 24'h400000, 17'd20000, 17'd20000, 17'd20000,
			24'h111111, 24'h222222, 1'b1, 1'b0, 1'b0));
		send(mk(24'h050000, 24'h060000, 24'h070000, 17'd30000, 17'd40000, 17'd50000,
			24'h333333, 24'h444444, 1'b1, 1'b0, 1'b0));
		send(mk(24'hF00000, 24'h0F0000, 24'h00F000, 17'd10000, 17'd20000, 17'd30000,
			24'h666666, 24'h777777, 1'b0, 1'b1, 1'b0));

		for (int p = 0; p < 4; p++) begin
			drain();
			apb_access(1'b1, ADDR_HAS_DEPTH, {31'b0, p[0]});
			apb_access(1'b1, ADDR_HAS_DEPTH_BACK, {31'b0, p[1]});
			apb_access(1'b0, ADDR_HAS_DEPTH, '0);
			apb_access(1'b0, ADDR_HAS_DEPTH_BACK, '0);
			target = sent + PHASE_ITEMS;
			while (sent < target) begin
				send_pixel();
				if (p == 1 && !paused && sent >= target - PHASE_ITEMS / 2) begin
					drain();
					paused = 1'b1;
				end
			end
		end

		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
hdl/dsf_pkg.sv
hdl/dsf_update.sv
hdl/deep_sample_flatten_top.sv
tb/deep_sample_flatten_checker.sv
tb/tb_deep_sample_flatten_top.sv
